// File: rtl/core/ldti_pkg.sv
// Package for the log-domain trilinear interpolator: field widths, op codes,
// level type and the small arithmetic helpers of the pairwise log blend.
// No dependencies.
package ldti_pkg;

    localparam int IDX_W               = 12;
    localparam int LVL_W               = 16;
    localparam int DIFF_W              = LVL_W + 1;
    localparam int CODE_W              = 8;
    localparam int TABLE_DEPTH_DEFAULT = 4096;
    localparam int DIFF_CLAMP          = 4095;
    localparam int LEVEL_OFFSET        = 1200;
    localparam int LEVEL_THRESHOLD     = 100;
    localparam int INDEX_CLAMP         = 4095;

    typedef enum logic [1:0] {
        OP_LOAD_DIFF = 2'd0,
        OP_LOAD_CODE = 2'd1,
        OP_INTERP    = 2'd2
    } t_op;

    typedef logic signed [LVL_W-1:0] t_level;

    // Add a signed 13-bit adjust to a 16-bit level, wrapping to 16 bits
    function automatic t_level f_add_adj(input logic [LVL_W-1:0] v,
                                         input logic signed [12:0] adj);
        logic [LVL_W-1:0] ext;
        ext = {{(LVL_W-13){adj[12]}}, adj};
        return t_level'(v + ext);
    endfunction

    // Larger of two levels
    function automatic t_level f_max(input t_level a, input t_level b);
        return (a > b) ? a : b;
    endfunction

    // Exact |a-b| clamped to the diff table range
    function automatic logic [IDX_W-1:0] f_diff_idx(input t_level a, input t_level b);
        logic [DIFF_W-1:0] d;
        d = (a > b) ? ({a[LVL_W-1], a} - {b[LVL_W-1], b})
                    : ({b[LVL_W-1], b} - {a[LVL_W-1], a});
        return (d > DIFF_W'(DIFF_CLAMP)) ? IDX_W'(DIFF_CLAMP) : d[IDX_W-1:0];
    endfunction

    // Subtract the table correction from the larger level, wrapping
    function automatic t_level f_finish(input t_level hi, input logic [LVL_W-1:0] corr);
        logic [LVL_W-1:0] r;
        r = hi - corr;
        return t_level'(r);
    endfunction

endpackage

// File: rtl/core/ldti_if.sv
// Stream interfaces of the log-domain trilinear interpolator: the request
// channel (ops and samples) and the result channel. No dependencies.

interface ldti_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [11:0]         table_index;
    logic [15:0]         table_data;
    logic [63:0]         lower_samples;
    logic [63:0]         upper_samples;
    logic signed [12:0]  az_adjust_near;
    logic signed [12:0]  az_adjust_far;
    logic signed [12:0]  range_adjust_near;
    logic signed [12:0]  range_adjust_far;
    logic signed [12:0]  elev_adjust_low;
    logic signed [12:0]  elev_adjust_high;

    modport source (
        output valid, op, table_index, table_data, lower_samples, upper_samples,
               az_adjust_near, az_adjust_far, range_adjust_near, range_adjust_far,
               elev_adjust_low, elev_adjust_high,
        input  ready
    );
    modport sink (
        input  valid, op, table_index, table_data, lower_samples, upper_samples,
               az_adjust_near, az_adjust_far, range_adjust_near, range_adjust_far,
               elev_adjust_low, elev_adjust_high,
        output ready
    );
endinterface

interface ldti_out_if;
    logic                valid;
    logic                ready;
    logic                cell_written;
    logic [7:0]          cell_code;
    logic signed [15:0]  blended_level;
    logic                index_clamped;

    modport source (
        output valid, cell_written, cell_code, blended_level, index_clamped,
        input  ready
    );
    modport sink (
        input  valid, cell_written, cell_code, blended_level, index_clamped,
        output ready
    );
endinterface

// File: rtl/core/log_domain_trilinear_interp.sv
// Log-domain trilinear interpolator, eight-stage pipeline.
// Depends on ldti_pkg and the ldti_in_if / ldti_out_if interfaces.
//
// Usage: every transfer on i_cell carries one op. Op 0 writes a diff table
// entry, op 1 writes a code table entry (low byte kept), op 2 interpolates one
// grid cell from eight 16-bit samples and six adjusts. Every transfer gives
// exactly one transfer on o_result, in order; load ops give an all-zero result.
// Load the tables before the first interpolation that reads them.
// Throughput: one item per cycle while the receiver takes results. The blend
// tree is cut into three levels of table lookup, each a compare stage (with a
// registered table read) and a subtract/adjust stage; four diff table copies
// (two for the first level, one for each later level) let every level look up
// in parallel.
// A table write is applied to each copy as the load op passes that copy's
// stage, so items keep their order against loads.
// Reset clears all stage valid bits; the tables are not cleared.
// When the receiver stalls, the output register holds and each stage holds
// only while the stage after it is full, so bubbles close up and new
// requests are still taken until the pipeline is full.
module log_domain_trilinear_interp #(
    parameter int TABLE_DEPTH = ldti_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ldti_in_if.sink    i_cell,
    ldti_out_if.source o_result
);
    import ldti_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = ($clog2(TABLE_DEPTH + 1) > IDX_W + 1) ?
                           $clog2(TABLE_DEPTH + 1) : IDX_W + 1;
    localparam int LAST  = 8;

    function automatic logic f_in_range(input logic [IDX_W-1:0] x);
        return CW'(x) < CW'(TABLE_DEPTH);
    endfunction

    // Table copies
    logic [LVL_W-1:0]  r_diff_mem0 [TABLE_DEPTH];
    logic [LVL_W-1:0]  r_diff_mem1 [TABLE_DEPTH];
    logic [LVL_W-1:0]  r_diff_mem2 [TABLE_DEPTH];
    logic [LVL_W-1:0]  r_diff_mem3 [TABLE_DEPTH];
    logic [CODE_W-1:0] r_code_mem  [TABLE_DEPTH];

    // Stage control
    logic [LAST:1] r_vld;
    logic [LAST:1] en;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        en[LAST] = !r_vld[LAST] || o_result.ready;
        for (int k = LAST - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_cell.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_cell.valid;
            end
            for (int k = 2; k <= LAST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: capture request, add azimuth adjusts to the samples
    t_op               r_s1_op;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [LVL_W-1:0]  r_s1_data;
    t_level            r_s1_x [4];
    t_level            r_s1_y [4];
    logic signed [12:0] r_s1_rng_near, r_s1_rng_far, r_s1_elev_low, r_s1_elev_high;
    t_level            n_s1_x [4];
    t_level            n_s1_y [4];

    // Pairs 0,1: lower elevation far/near bin; pairs 2,3: upper elevation
    always_comb begin
        logic [63:0] smp;
        for (int p = 0; p < 4; p++) begin
            smp = (p >= 2) ? i_cell.upper_samples : i_cell.lower_samples;
            n_s1_x[p] = f_add_adj(smp[32*(p & 1) + 16 +: 16], i_cell.az_adjust_far);
            n_s1_y[p] = f_add_adj(smp[32*(p & 1) +: 16], i_cell.az_adjust_near);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_op        <= t_op'(i_cell.op);
            r_s1_idx       <= i_cell.table_index;
            r_s1_data      <= i_cell.table_data;
            r_s1_x         <= n_s1_x;
            r_s1_y         <= n_s1_y;
            r_s1_rng_near  <= i_cell.range_adjust_near;
            r_s1_rng_far   <= i_cell.range_adjust_far;
            r_s1_elev_low  <= i_cell.elev_adjust_low;
            r_s1_elev_high <= i_cell.elev_adjust_high;
        end
    end

    // Stage 2: azimuth blend compare, diff lookup in copies 0 and 1
    t_op               r_s2_op;
    logic [IDX_W-1:0]  r_s2_idx;
    logic [LVL_W-1:0]  r_s2_data;
    t_level            r_s2_hi [4];
    logic [3:0]        r_s2_ok;
    logic [LVL_W-1:0]  r_s2_rd [4];
    logic signed [12:0] r_s2_rng_near, r_s2_rng_far, r_s2_elev_low, r_s2_elev_high;
    t_level            n_s2_hi [4];
    logic [IDX_W-1:0]  n_s2_didx [4];

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            n_s2_hi[p]   = f_max(r_s1_x[p], r_s1_y[p]);
            n_s2_didx[p] = f_diff_idx(r_s1_x[p], r_s1_y[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_op        <= r_s1_op;
            r_s2_idx       <= r_s1_idx;
            r_s2_data      <= r_s1_data;
            r_s2_hi        <= n_s2_hi;
            r_s2_rng_near  <= r_s1_rng_near;
            r_s2_rng_far   <= r_s1_rng_far;
            r_s2_elev_low  <= r_s1_elev_low;
            r_s2_elev_high <= r_s1_elev_high;
            for (int p = 0; p < 4; p++) begin
                r_s2_ok[p] <= f_in_range(n_s2_didx[p]);
            end
            r_s2_rd[0] <= r_diff_mem0[AW'(n_s2_didx[0])];
            r_s2_rd[1] <= r_diff_mem0[AW'(n_s2_didx[1])];
            r_s2_rd[2] <= r_diff_mem1[AW'(n_s2_didx[2])];
            r_s2_rd[3] <= r_diff_mem1[AW'(n_s2_didx[3])];
            if (r_vld[1] && r_s1_op == OP_LOAD_DIFF && f_in_range(r_s1_idx)) begin
                r_diff_mem0[AW'(r_s1_idx)] <= r_s1_data;
                r_diff_mem1[AW'(r_s1_idx)] <= r_s1_data;
            end
        end
    end

    // Stage 3: finish azimuth blends, add range adjusts
    t_op               r_s3_op;
    logic [IDX_W-1:0]  r_s3_idx;
    logic [LVL_W-1:0]  r_s3_data;
    t_level            r_s3_x [2];
    t_level            r_s3_y [2];
    logic signed [12:0] r_s3_elev_low, r_s3_elev_high;
    t_level            n_s3_b [4];
    t_level            n_s3_x [2];
    t_level            n_s3_y [2];

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            n_s3_b[p] = f_finish(r_s2_hi[p], r_s2_ok[p] ? r_s2_rd[p] : '0);
        end
        for (int e = 0; e < 2; e++) begin
            n_s3_x[e] = f_add_adj(n_s3_b[2*e], r_s2_rng_far);
            n_s3_y[e] = f_add_adj(n_s3_b[2*e+1], r_s2_rng_near);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_op        <= r_s2_op;
            r_s3_idx       <= r_s2_idx;
            r_s3_data      <= r_s2_data;
            r_s3_x         <= n_s3_x;
            r_s3_y         <= n_s3_y;
            r_s3_elev_low  <= r_s2_elev_low;
            r_s3_elev_high <= r_s2_elev_high;
        end
    end

    // Stage 4: range blend compare, diff lookup in copy 2
    t_op               r_s4_op;
    logic [IDX_W-1:0]  r_s4_idx;
    logic [LVL_W-1:0]  r_s4_data;
    t_level            r_s4_hi [2];
    logic [1:0]        r_s4_ok;
    logic [LVL_W-1:0]  r_s4_rd [2];
    logic signed [12:0] r_s4_elev_low, r_s4_elev_high;
    logic [IDX_W-1:0]  n_s4_didx [2];

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            n_s4_didx[e] = f_diff_idx(r_s3_x[e], r_s3_y[e]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_op        <= r_s3_op;
            r_s4_idx       <= r_s3_idx;
            r_s4_data      <= r_s3_data;
            r_s4_elev_low  <= r_s3_elev_low;
            r_s4_elev_high <= r_s3_elev_high;
            for (int e = 0; e < 2; e++) begin
                r_s4_hi[e] <= f_max(r_s3_x[e], r_s3_y[e]);
                r_s4_ok[e] <= f_in_range(n_s4_didx[e]);
            end
            r_s4_rd[0] <= r_diff_mem2[AW'(n_s4_didx[0])];
            r_s4_rd[1] <= r_diff_mem2[AW'(n_s4_didx[1])];
            if (r_vld[3] && r_s3_op == OP_LOAD_DIFF && f_in_range(r_s3_idx)) begin
                r_diff_mem2[AW'(r_s3_idx)] <= r_s3_data;
            end
        end
    end

    // Stage 5: finish range blends, add elevation adjusts
    t_op               r_s5_op;
    logic [IDX_W-1:0]  r_s5_idx;
    logic [LVL_W-1:0]  r_s5_data;
    t_level            r_s5_x, r_s5_y;
    t_level            n_s5_b [2];

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            n_s5_b[e] = f_finish(r_s4_hi[e], r_s4_ok[e] ? r_s4_rd[e] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_op   <= r_s4_op;
            r_s5_idx  <= r_s4_idx;
            r_s5_data <= r_s4_data;
            r_s5_x    <= f_add_adj(n_s5_b[0], r_s4_elev_low);
            r_s5_y    <= f_add_adj(n_s5_b[1], r_s4_elev_high);
        end
    end

    // Stage 6: elevation blend compare, diff lookup in copy 3
    t_op               r_s6_op;
    logic [IDX_W-1:0]  r_s6_idx;
    logic [LVL_W-1:0]  r_s6_data;
    t_level            r_s6_hi;
    logic              r_s6_ok;
    logic [LVL_W-1:0]  r_s6_rd;
    logic [IDX_W-1:0]  n_s6_didx;

    assign n_s6_didx = f_diff_idx(r_s5_x, r_s5_y);

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_op   <= r_s5_op;
            r_s6_idx  <= r_s5_idx;
            r_s6_data <= r_s5_data;
            r_s6_hi   <= f_max(r_s5_x, r_s5_y);
            r_s6_ok   <= f_in_range(n_s6_didx);
            r_s6_rd   <= r_diff_mem3[AW'(n_s6_didx)];
            if (r_vld[5] && r_s5_op == OP_LOAD_DIFF && f_in_range(r_s5_idx)) begin
                r_diff_mem3[AW'(r_s5_idx)] <= r_s5_data;
            end
        end
    end

    // Stage 7: final level, threshold and index clamp, code lookup
    logic              r_s7_interp;
    t_level            r_s7_level;
    logic              r_s7_hit;
    logic              r_s7_clamp;
    logic              r_s7_cok;
    logic [CODE_W-1:0] r_s7_crd;
    t_level            n_s7_level;
    logic              n_s7_clamp;
    logic [IDX_W-1:0]  n_s7_cidx;

    always_comb begin
        n_s7_level = t_level'(f_finish(r_s6_hi, r_s6_ok ? r_s6_rd : '0)
                              - t_level'(LEVEL_OFFSET));
        n_s7_clamp = n_s7_level > t_level'(INDEX_CLAMP);
        n_s7_cidx  = n_s7_clamp ? IDX_W'(INDEX_CLAMP) : n_s7_level[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_interp <= (r_s6_op == OP_INTERP);
            r_s7_level  <= n_s7_level;
            r_s7_hit    <= (r_s6_op == OP_INTERP) &&
                           (n_s7_level > t_level'(LEVEL_THRESHOLD));
            r_s7_clamp  <= n_s7_clamp;
            r_s7_cok    <= f_in_range(n_s7_cidx);
            r_s7_crd    <= r_code_mem[AW'(n_s7_cidx)];
            if (r_vld[6] && r_s6_op == OP_LOAD_CODE && f_in_range(r_s6_idx)) begin
                r_code_mem[AW'(r_s6_idx)] <= r_s6_data[CODE_W-1:0];
            end
        end
    end

    // Stage 8: output register, zero fields of load ops and misses
    logic              r_out_written;
    logic [CODE_W-1:0] r_out_code;
    t_level            r_out_level;
    logic              r_out_clamped;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_out_written <= r_s7_hit;
            r_out_code    <= (r_s7_hit && r_s7_cok) ? r_s7_crd : '0;
            r_out_level   <= r_s7_interp ? r_s7_level : '0;
            r_out_clamped <= r_s7_hit && r_s7_clamp;
        end
    end

    assign o_result.valid         = r_vld[LAST];
    assign o_result.cell_written  = r_out_written;
    assign o_result.cell_code     = r_out_code;
    assign o_result.blended_level = r_out_level;
    assign o_result.index_clamped = r_out_clamped;

`ifndef SYNTH
    a_clamp_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.index_clamped |-> o_result.cell_written)
        else $error("index clamp flagged without a written cell");

    a_code_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.cell_written |-> o_result.cell_code == '0)
        else $error("nonzero code on a cell that was not written");

    a_written_above_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.cell_written |->
        o_result.blended_level > t_level'(LEVEL_THRESHOLD))
        else $error("cell written at a level not above threshold");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");
`endif

endmodule
